>>> sv/sbpb_pkg.sv
// types, constants and register codes for the spectrum bar and peak block
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps

package sbpb_pkg;

  // field widths
  localparam int BAND_W  = 8;
  localparam int MAG_W   = 24;
  localparam int LVL_W   = 16;
  localparam int NEGL_W  = 21;
  localparam int MDB_W   = 16;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int CNT_IN_W = 9;

  // 6.0206 in Q3.13, the shift of the dB product and its saturation value
  localparam logic [15:0] DB_PER_LOG2 = 16'd49321;
  localparam int          DB_SHIFT    = 21;
  localparam logic [MDB_W-1:0] MDB_SAT = 16'd32768;

  // register reset values and band count limits
  localparam int          MIN_BANDS        = 4;
  localparam int          RST_BAND_COUNT   = 32;
  localparam logic [15:0] RST_DECAY        = 16'd51118;
  localparam logic [15:0] RST_FALL         = 16'd786;
  localparam logic [15:0] RST_FLOOR        = 16'hC400;
  localparam logic [15:0] RST_GAIN         = 16'd19065;
  localparam logic [15:0] RST_HIDE         = 16'd1311;

  typedef enum logic [2:0] {
    REG_BAND_COUNT = 3'd0,
    REG_DECAY      = 3'd1,
    REG_FALL       = 3'd2,
    REG_FLOOR      = 3'd3,
    REG_GAIN       = 3'd4,
    REG_HIDE       = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [15:0]        decay_factor;
    logic [15:0]        peak_fall_step;
    logic signed [15:0] db_floor;
    logic [15:0]        db_gain;
    logic [15:0]        peak_hide_level;
  } cfg_t;

  // stage one: negated log2 in Q.16
  typedef struct packed {
    logic              valid;
    logic [BAND_W-1:0] band;
    logic              err;
    logic              zero;
    logic [NEGL_W-1:0] neg_l;
  } log_st_t;

  // stage two: magnitude of the dB value in Q8.8
  typedef struct packed {
    logic              valid;
    logic [BAND_W-1:0] band;
    logic              err;
    logic              zero;
    logic [MDB_W-1:0]  mag_db;
  } db_st_t;

  // stage three: dB above floor, clipped at zero
  typedef struct packed {
    logic              valid;
    logic [BAND_W-1:0] band;
    logic              err;
    logic [15:0]       dpos;
  } dist_st_t;

  // stage four: normalised level
  typedef struct packed {
    logic              valid;
    logic [BAND_W-1:0] band;
    logic              err;
    logic [LVL_W-1:0]  level;
  } lvl_st_t;

  typedef struct packed {
    logic [BAND_W-1:0] band_echo;
    logic [LVL_W-1:0]  bar_level;
    logic [LVL_W-1:0]  peak_level;
    logic              peak_visible;
    logic              index_error;
  } res_t;

endpackage

>>> sv/sbpb_if.sv
// valid/ready channel interfaces for the input items and the results
// depends on sbpb_pkg for the field widths
`timescale 1ns / 1ps

interface sbpb_in_if;
  logic                         valid;
  logic                         ready;
  logic [sbpb_pkg::BAND_W-1:0]  band;
  logic [sbpb_pkg::MAG_W-1:0]   magnitude;

  modport source (output valid, band, magnitude, input ready);
  modport sink   (input valid, band, magnitude, output ready);
endinterface

interface sbpb_out_if;
  logic                         valid;
  logic                         ready;
  logic [sbpb_pkg::BAND_W-1:0]  band_echo;
  logic [sbpb_pkg::LVL_W-1:0]   bar_level;
  logic [sbpb_pkg::LVL_W-1:0]   peak_level;
  logic                         peak_visible;
  logic                         index_error;

  modport source (output valid, band_echo, bar_level, peak_level, peak_visible, index_error,
                  input ready);
  modport sink   (input valid, band_echo, bar_level, peak_level, peak_visible, index_error,
                  output ready);
endinterface

>>> sv/sbpb_cfg.sv
// apb register file: band count, decay, peak fall, dB floor, gain, hide level
// depends on sbpb_pkg; raises a clear pulse on every band count write
`timescale 1ns / 1ps

module sbpb_cfg #(
  parameter int MAX_BANDS = 256,
  parameter int CNT_W     = 9
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sbpb_pkg::PADDR_W-1:0]     paddr,
  input  logic [sbpb_pkg::PDATA_W-1:0]     pwdata,
  output logic [sbpb_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  output sbpb_pkg::cfg_t                   cfg_o,
  output logic [CNT_W-1:0]                 band_count_o,
  output logic                             clr_o
);

  localparam int CMP_W   = (CNT_W > sbpb_pkg::CNT_IN_W) ? CNT_W : sbpb_pkg::CNT_IN_W;
  localparam int CNT_RST = (MAX_BANDS < sbpb_pkg::RST_BAND_COUNT) ?
                           MAX_BANDS : sbpb_pkg::RST_BAND_COUNT;

  sbpb_pkg::cfg_t      cfg_q;
  logic [CNT_W-1:0]    count_q;
  logic [CMP_W-1:0]    count_wr;
  logic [CMP_W-1:0]    count_clamped;
  logic                wr_en;
  sbpb_pkg::reg_idx_e  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = sbpb_pkg::reg_idx_e'(paddr[sbpb_pkg::PADDR_W-1:2]);

  // clamp a written band count into the supported range
  always_comb begin
    count_wr = CMP_W'(pwdata[sbpb_pkg::CNT_IN_W-1:0]);
    if (count_wr < CMP_W'(sbpb_pkg::MIN_BANDS)) begin
      count_clamped = CMP_W'(sbpb_pkg::MIN_BANDS);
    end else if (count_wr > CMP_W'(MAX_BANDS)) begin
      count_clamped = CMP_W'(MAX_BANDS);
    end else begin
      count_clamped = count_wr;
    end
  end

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q               <= CNT_W'(CNT_RST);
      cfg_q.decay_factor    <= sbpb_pkg::RST_DECAY;
      cfg_q.peak_fall_step  <= sbpb_pkg::RST_FALL;
      cfg_q.db_floor        <= signed'(sbpb_pkg::RST_FLOOR);
      cfg_q.db_gain         <= sbpb_pkg::RST_GAIN;
      cfg_q.peak_hide_level <= sbpb_pkg::RST_HIDE;
      clr_o                 <= 1'b0;
    end else begin
      clr_o <= 1'b0;
      if (wr_en) begin
        case (idx)
          sbpb_pkg::REG_BAND_COUNT: begin
            count_q <= CNT_W'(count_clamped);
            clr_o   <= 1'b1;
          end
          sbpb_pkg::REG_DECAY: cfg_q.decay_factor    <= pwdata[15:0];
          sbpb_pkg::REG_FALL:  cfg_q.peak_fall_step  <= pwdata[15:0];
          sbpb_pkg::REG_FLOOR: cfg_q.db_floor        <= signed'(pwdata[15:0]);
          sbpb_pkg::REG_GAIN:  cfg_q.db_gain         <= pwdata[15:0];
          sbpb_pkg::REG_HIDE:  cfg_q.peak_hide_level <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  // read back
  always_comb begin
    case (idx)
      sbpb_pkg::REG_BAND_COUNT: prdata = sbpb_pkg::PDATA_W'(count_q);
      sbpb_pkg::REG_DECAY:      prdata = {16'd0, cfg_q.decay_factor};
      sbpb_pkg::REG_FALL:       prdata = {16'd0, cfg_q.peak_fall_step};
      sbpb_pkg::REG_FLOOR:      prdata = {16'd0, cfg_q.db_floor};
      sbpb_pkg::REG_GAIN:       prdata = {16'd0, cfg_q.db_gain};
      sbpb_pkg::REG_HIDE:       prdata = {16'd0, cfg_q.peak_hide_level};
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o        = cfg_q;
  assign band_count_o = count_q;

endmodule

>>> sv/sbpb_log_db.sv
// stages one and two: mitchell log2 of the magnitude, then scaling to dB
// depends on sbpb_pkg; advances on the shared pipeline enable
`timescale 1ns / 1ps

module sbpb_log_db (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [sbpb_pkg::BAND_W-1:0]    band_i,
  input  logic [sbpb_pkg::MAG_W-1:0]     magnitude_i,
  input  logic                           err_i,
  output sbpb_pkg::db_st_t               st_o
);

  localparam int PROD_W = sbpb_pkg::NEGL_W + 16;

  sbpb_pkg::log_st_t  s1_d, s1_q;
  sbpb_pkg::db_st_t   s2_d, s2_q;
  logic [4:0]                      k;
  logic [sbpb_pkg::MAG_W-1:0]      mnorm;
  logic [PROD_W-1:0]               prod;
  logic [PROD_W-1:0]               rounded;
  logic [sbpb_pkg::MDB_W-1:0]      mdb;

  // top set bit, normalise, fraction below the leading one
  always_comb begin
    k = '0;
    for (int i = 0; i < sbpb_pkg::MAG_W; i++) begin
      if (magnitude_i[i]) begin
        k = 5'(i);
      end
    end
    mnorm      = magnitude_i << (5'd23 - k);
    s1_d.valid = valid_i;
    s1_d.band  = band_i;
    s1_d.err   = err_i;
    s1_d.zero  = (magnitude_i == '0);
    s1_d.neg_l = {5'd24 - k, 16'd0} - {5'd0, mnorm[22:7]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (en_i) begin
      s1_q <= s1_d;
    end
  end

  // times 6.0206, round half up, saturate
  always_comb begin
    prod    = PROD_W'(s1_q.neg_l) * PROD_W'(sbpb_pkg::DB_PER_LOG2);
    rounded = prod + (PROD_W'(1) << (sbpb_pkg::DB_SHIFT - 1));
    mdb     = rounded[sbpb_pkg::DB_SHIFT +: sbpb_pkg::MDB_W];
    s2_d.valid  = s1_q.valid;
    s2_d.band   = s1_q.band;
    s2_d.err    = s1_q.err;
    s2_d.zero   = s1_q.zero;
    s2_d.mag_db = (mdb > sbpb_pkg::MDB_SAT) ? sbpb_pkg::MDB_SAT : mdb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign st_o = s2_q;

endmodule

>>> sv/sbpb_level.sv
// stages three and four: dB above floor, then gain into a clamped Q0.16 level
// depends on sbpb_pkg; advances on the shared pipeline enable
`timescale 1ns / 1ps

module sbpb_level (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  sbpb_pkg::cfg_t                 cfg_i,
  input  sbpb_pkg::db_st_t               st_i,
  output logic [sbpb_pkg::BAND_W-1:0]    s3_band_o,
  output sbpb_pkg::lvl_st_t              st_o
);

  sbpb_pkg::dist_st_t  s3_d, s3_q;
  sbpb_pkg::lvl_st_t   s4_d, s4_q;
  logic signed [17:0]  above;
  logic [31:0]         prod;
  logic [19:0]         scaled;

  // distance above the floor; a zero magnitude sits on the floor
  always_comb begin
    above = 18'sd0 - $signed({2'b00, st_i.mag_db})
          - $signed({{2{cfg_i.db_floor[15]}}, cfg_i.db_floor});
    s3_d.valid = st_i.valid;
    s3_d.band  = st_i.band;
    s3_d.err   = st_i.err;
    if (st_i.zero || (above <= 18'sd0)) begin
      s3_d.dpos = '0;
    end else begin
      s3_d.dpos = above[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (en_i) begin
      s3_q <= s3_d;
    end
  end

  // gain in Q4.12, saturate to full scale
  always_comb begin
    prod   = 32'(s3_q.dpos) * 32'(cfg_i.db_gain);
    scaled = prod[31:12];
    s4_d.valid = s3_q.valid;
    s4_d.band  = s3_q.band;
    s4_d.err   = s3_q.err;
    s4_d.level = (|scaled[19:16]) ? 16'hFFFF : scaled[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q <= '0;
    end else if (en_i) begin
      s4_q <= s4_d;
    end
  end

  assign s3_band_o = s3_q.band;
  assign st_o      = s4_q;

endmodule

>>> sv/sbpb_update.sv
// per-band bar and peak store with read-modify-write and the result register
// depends on sbpb_pkg; the store is read one stage ahead and the last write forwarded
`timescale 1ns / 1ps

module sbpb_update #(
  parameter int MAX_BANDS = 256,
  parameter int IDX_W     = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           clr_i,
  input  sbpb_pkg::cfg_t                 cfg_i,
  input  logic [sbpb_pkg::BAND_W-1:0]    rd_band_i,
  input  sbpb_pkg::lvl_st_t              st_i,
  output logic                           out_valid_o,
  output sbpb_pkg::res_t                 res_o
);

  localparam int LW = sbpb_pkg::LVL_W;

  logic [2*LW-1:0]     mem [MAX_BANDS];
  logic [MAX_BANDS-1:0] vld_q;
  logic [2*LW-1:0]     rd_q;
  logic                rd_vld_q;
  logic [IDX_W-1:0]    raddr, waddr;
  logic [15:0]         rd_ext, wr_ext;

  logic                fwd_v_q;
  logic [IDX_W-1:0]    fwd_idx_q;
  logic [LW-1:0]       fwd_bar_q, fwd_peak_q;

  logic [LW-1:0]       old_bar, old_peak, decayed, bar, peak_dec, peak;
  logic [2*LW-1:0]     prod;
  logic                do_wr;

  sbpb_pkg::res_t      res_d, res_q;
  logic                out_valid_q;

  assign rd_ext = {8'd0, rd_band_i};
  assign wr_ext = {8'd0, st_i.band};
  assign raddr  = rd_ext[IDX_W-1:0];
  assign waddr  = wr_ext[IDX_W-1:0];
  assign do_wr  = en_i && st_i.valid && !st_i.err;

  // store array: read for the item entering stage four, write for the one leaving
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (do_wr) begin
        mem[waddr] <= {bar, peak};
      end
      rd_q <= mem[raddr];
    end
  end

  // entry valid bits, cleared by reset and by a band count write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (clr_i) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (en_i) begin
      rd_vld_q <= vld_q[raddr];
      if (do_wr) begin
        vld_q[waddr] <= 1'b1;
      end
    end
  end

  // last write, for a read that met it at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else if (clr_i) begin
      fwd_v_q <= 1'b0;
    end else if (en_i) begin
      fwd_v_q <= st_i.valid && !st_i.err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fwd_idx_q  <= waddr;
      fwd_bar_q  <= bar;
      fwd_peak_q <= peak;
    end
  end

  // bar decay, peak hold and fall, and the result fields
  always_comb begin
    if (fwd_v_q && (fwd_idx_q == waddr)) begin
      old_bar  = fwd_bar_q;
      old_peak = fwd_peak_q;
    end else if (rd_vld_q) begin
      old_bar  = rd_q[2*LW-1:LW];
      old_peak = rd_q[LW-1:0];
    end else begin
      old_bar  = '0;
      old_peak = '0;
    end
    prod     = (2*LW)'(old_bar) * (2*LW)'(cfg_i.decay_factor);
    decayed  = prod[2*LW-1:LW];
    bar      = (st_i.level > decayed) ? st_i.level : decayed;
    peak_dec = (old_peak > cfg_i.peak_fall_step) ? old_peak - cfg_i.peak_fall_step : '0;
    peak     = (bar > old_peak) ? bar : peak_dec;

    res_d.band_echo = st_i.band;
    if (st_i.err) begin
      res_d.bar_level    = '0;
      res_d.peak_level   = '0;
      res_d.peak_visible = 1'b0;
      res_d.index_error  = 1'b1;
    end else begin
      res_d.bar_level    = bar;
      res_d.peak_level   = peak;
      res_d.peak_visible = (peak >= cfg_i.peak_hide_level);
      res_d.index_error  = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= st_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

>>> sv/spectrum_bar_peak_ballistics.sv
// top level of the spectrum bar and peak block: pipeline, stores and apb registers
// depends on sbpb_pkg, sbpb_if, sbpb_cfg, sbpb_log_db, sbpb_level and sbpb_update
`timescale 1ns / 1ps

// usage
//   in_i carries one band index and its Q0.24 magnitude per transfer; out_o returns
//   one result per item, in order: band echo, bar, peak, peak visible and index error.
//   the apb port holds band count, decay, peak fall, dB floor, gain and hide level;
//   write it only while no item is in flight. a band count write clears all bars and
//   peaks, and the stores read as zero after reset, with the registers at their
//   reset values.
// pipeline
//   one item a cycle while the output is not stalled. the input transfer loads the log2
//   stage, and the item then moves through dB scaling, floor offset, gain and the store
//   update into the output register, where its result is offered.
//   the store read is issued one stage ahead of the update and the previous write is
//   forwarded, so the same band may follow itself on consecutive cycles.
// stalls
//   the whole pipeline moves on one enable, high while the output register is empty
//   or being taken. when the receiver holds ready low with a result waiting,
//   in_i.ready drops and every stage holds its item.

module spectrum_bar_peak_ballistics #(
  parameter int MAX_BANDS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sbpb_in_if.sink                        in_i,
  sbpb_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sbpb_pkg::PADDR_W-1:0]   paddr,
  input  logic [sbpb_pkg::PDATA_W-1:0]   pwdata,
  output logic [sbpb_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int IDX_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int CNT_W = $clog2(MAX_BANDS + 1);
  localparam int CMP_W = (CNT_W > sbpb_pkg::BAND_W) ? CNT_W : sbpb_pkg::BAND_W;

  sbpb_pkg::cfg_t                cfg;
  logic [CNT_W-1:0]              band_count;
  logic                          clr;
  logic                          en;
  logic                          in_err;
  sbpb_pkg::db_st_t              db_st;
  sbpb_pkg::lvl_st_t             lvl_st;
  logic [sbpb_pkg::BAND_W-1:0]   s3_band;
  logic                          out_valid;
  sbpb_pkg::res_t                res;

  // pipeline enable
  assign en         = !out_valid || out_o.ready;
  assign in_i.ready = en;
  assign in_err     = (CMP_W'(in_i.band) >= CMP_W'(band_count));

  sbpb_cfg #(
    .MAX_BANDS (MAX_BANDS),
    .CNT_W     (CNT_W)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .cfg_o        (cfg),
    .band_count_o (band_count),
    .clr_o        (clr)
  );

  sbpb_log_db u_log_db (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_i.valid),
    .band_i      (in_i.band),
    .magnitude_i (in_i.magnitude),
    .err_i       (in_err),
    .st_o        (db_st)
  );

  sbpb_level u_level (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .cfg_i     (cfg),
    .st_i      (db_st),
    .s3_band_o (s3_band),
    .st_o      (lvl_st)
  );

  sbpb_update #(
    .MAX_BANDS (MAX_BANDS),
    .IDX_W     (IDX_W)
  ) u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .clr_i       (clr),
    .cfg_i       (cfg),
    .rd_band_i   (s3_band),
    .st_i        (lvl_st),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  // result transfer
  assign out_o.valid        = out_valid;
  assign out_o.band_echo    = res.band_echo;
  assign out_o.bar_level    = res.bar_level;
  assign out_o.peak_level   = res.peak_level;
  assign out_o.peak_visible = res.peak_visible;
  assign out_o.index_error  = res.index_error;

endmodule
